/* rtl/core/kti_pkg.sv */
// ----------------------------------------------------------------------------
// kti_pkg: keyframe translation interpolation shared types
// Word layouts, register indexes, pipeline sizing and the arithmetic helpers.
// ----------------------------------------------------------------------------
package kti_pkg;

   localparam int KEYFRAMES = 256;
   localparam int KF_AW     = $clog2(KEYFRAMES);
   localparam int STAGES    = 11;
   localparam int DIV_STEPS = 4;   // quotient bits resolved per divider stage
   localparam int ROW_W     = 54;
   localparam int COEF_W    = 18;

   localparam logic [ROW_W-1:0] ROW0_RESET = ROW_W'(65536);
   localparam logic [ROW_W-1:0] ROW1_RESET = ROW_W'(65536) << COEF_W;
   localparam logic [ROW_W-1:0] ROW2_RESET = ROW_W'(65536) << (2 * COEF_W);

   typedef enum logic [2:0] {
      CSR_ROT_ROW0 = 3'd0,
      CSR_ROT_ROW1 = 3'd1,
      CSR_ROT_ROW2 = 3'd2,
      CSR_BASE_X   = 3'd3,
      CSR_BASE_Y   = 3'd4,
      CSR_BASE_Z   = 3'd5
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_RANGE     = 2'd1,
      ST_ZERO_DUR  = 2'd2
   } status_type;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic [7:0]         slot;
      logic signed [31:0] key_x;
      logic signed [31:0] key_y;
      logic signed [31:0] key_z;
      logic [15:0]        key_ticks;
      logic [7:0]         from_index;
      logic [7:0]         to_index;
      logic [15:0]        phase_start;
      logic [15:0]        phase_stop;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic [15:0]        ticks;
   } kf_type;

   // restoring divider state: top is the integer quotient bit (ratio of one)
   typedef struct packed {
      logic        top;
      logic [15:0] q;
      logic [15:0] r;
      logic [15:0] d;
   } div_type;

   typedef struct packed {
      logic       zero;     // force the coordinate outputs to zero
      logic [1:0] status;
   } fl_type;

   typedef struct packed {
      fl_type                 fl;
      logic                   fwd;    // end segment after start segment
      logic                   tneg;   // trailing ratio negative
      logic [2:0][32:0]       dfrom;  // p[from+1] - p[from], per axis
      logic [2:0][32:0]       dto;    // p[to+1] - p[to]
      logic [2:0][32:0]       mid;    // p[to] - p[from+1]
   } ctx_type;

   function automatic div_type div_step(div_type s);
      div_type     t;
      logic [16:0] r2;
      t = s;
      for (int i = 0; i < DIV_STEPS; i++) begin
         r2 = {t.r, 1'b0};
         if (r2 >= {1'b0, t.d}) begin
            t.r = 16'(r2 - {1'b0, t.d});
            t.q = {t.q[14:0], 1'b1};
         end else begin
            t.r = r2[15:0];
            t.q = {t.q[14:0], 1'b0};
         end
      end
      return t;
   endfunction

   // shift right by 16, ties away from zero
   function automatic logic signed [34:0] rnd51(logic signed [50:0] p);
      logic signed [50:0] t;
      t = p + (p[50] ? 51'sd32767 : 51'sd32768);
      return 35'(t >>> 16);
   endfunction

   function automatic logic signed [39:0] rnd56(logic signed [55:0] p);
      logic signed [55:0] t;
      t = p + (p[55] ? 56'sd32767 : 56'sd32768);
      return 40'(t >>> 16);
   endfunction

endpackage

/* rtl/core/keyframe_translation_interp.sv */
// ----------------------------------------------------------------------------
// keyframe_translation_interp: keyframe translation interpolation
// Keyframe table with a pipelined ratio divider, delta accumulation, 3x3
// rotation and base offset.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle; each of the 11 stages holds one word and
//   stalls only when the stage after it is full and stalled.
// Ratio divider: 16 quotient bits over 4 stages, 4 bits per stage.
// Reset: clears stage valids and the config registers (identity matrix, zero
//   base). The keyframe tables are not cleared.
// ----------------------------------------------------------------------------
module keyframe_translation_interp (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  kti_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output kti_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [2:0]                     csr_addr,
   input  logic [kti_pkg::ROW_W-1:0]      csr_wdata
);

   localparam int N = kti_pkg::STAGES;
   localparam int AW = kti_pkg::KF_AW;

   // ---------------- config registers ----------------
   logic [kti_pkg::ROW_W-1:0] row_ff [3];
   logic signed [31:0]        base_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0]  <= kti_pkg::ROW0_RESET;
         row_ff[1]  <= kti_pkg::ROW1_RESET;
         row_ff[2]  <= kti_pkg::ROW2_RESET;
         base_ff[0] <= '0;
         base_ff[1] <= '0;
         base_ff[2] <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            kti_pkg::CSR_ROT_ROW0: row_ff[0]  <= csr_wdata;
            kti_pkg::CSR_ROT_ROW1: row_ff[1]  <= csr_wdata;
            kti_pkg::CSR_ROT_ROW2: row_ff[2]  <= csr_wdata;
            kti_pkg::CSR_BASE_X:   base_ff[0] <= csr_wdata[31:0];
            kti_pkg::CSR_BASE_Y:   base_ff[1] <= csr_wdata[31:0];
            kti_pkg::CSR_BASE_Z:   base_ff[2] <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // ---------------- stage valids and per-stage load enables ----------------
   // A stage loads when it is empty or its content moves on. Bubbles collapse.
   logic [N-1:0] v_ff, v_in, en;
   logic         accept;

   always_comb begin
      en[N-1] = !v_ff[N-1] || rsp_ready;
      for (int k = N - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_ready = en[0];
   assign accept    = req_valid && en[0];
   assign v_in      = {v_ff[N-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= (v_ff & ~en) | (v_in & en);
      end
   end

   // ---------------- stage 0: keyframe table ----------------
   // Two copies, both written by every write word: copy a serves from and
   // from+1, copy b serves to and to+1.
   kti_pkg::kf_type mem_a [kti_pkg::KEYFRAMES];
   kti_pkg::kf_type mem_b [kti_pkg::KEYFRAMES];
   kti_pkg::kf_type a0_ff, a1_ff, b0_ff, b1_ff, kf_wr;
   logic [AW-1:0]   wa, ra0, ra1, rb0, rb1;
   logic            slot_ok, wr_en, range_bad;

   assign slot_ok = 13'(req_data.slot) < 13'(kti_pkg::KEYFRAMES);
   assign wr_en   = accept && (req_data.cmd == kti_pkg::CMD_WRITE) && slot_ok;
   assign wa      = AW'(req_data.slot);
   assign ra0     = AW'(req_data.from_index);
   assign ra1     = ra0 + AW'(1);
   assign rb0     = AW'(req_data.to_index);
   assign rb1     = rb0 + AW'(1);
   assign kf_wr   = '{x: req_data.key_x, y: req_data.key_y, z: req_data.key_z,
                      ticks: req_data.key_ticks};
   // next keyframe must exist for both segments
   assign range_bad = (13'(req_data.from_index) > 13'(kti_pkg::KEYFRAMES - 2)) ||
                      (13'(req_data.to_index) > 13'(kti_pkg::KEYFRAMES - 2));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_a[wa] <= kf_wr;
         mem_b[wa] <= kf_wr;
      end
      if (en[0]) begin
         a0_ff <= mem_a[ra0];
         a1_ff <= mem_a[ra1];
         b0_ff <= mem_b[rb0];
         b1_ff <= mem_b[rb1];
      end
   end

   logic       qry0_ff, rbad0_ff, wbad0_ff;
   logic [7:0] from0_ff, to0_ff;
   logic [15:0] ps0_ff, pe0_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         qry0_ff  <= req_data.cmd == kti_pkg::CMD_QUERY;
         rbad0_ff <= range_bad;
         wbad0_ff <= !slot_ok;
         from0_ff <= req_data.from_index;
         to0_ff   <= req_data.to_index;
         ps0_ff   <= req_data.phase_start;
         pe0_ff   <= req_data.phase_stop;
      end
   end

   // ---------------- stage 1: status, deltas, divider setup ----------------
   kti_pkg::ctx_type c_ff [1:6];
   kti_pkg::ctx_type c1_in;
   kti_pkg::div_type dl_ff [1:5];
   kti_pkg::div_type dt_ff [1:5];
   kti_pkg::div_type dl1_in, dt1_in;
   logic signed [31:0] pa0 [3], pa1 [3], pb0 [3], pb1 [3];
   logic [15:0] tf, tt, ml, mt, nt;
   logic [16:0] pdiff;
   logic        fwd, same;

   assign pa0 = '{a0_ff.x, a0_ff.y, a0_ff.z};
   assign pa1 = '{a1_ff.x, a1_ff.y, a1_ff.z};
   assign pb0 = '{b0_ff.x, b0_ff.y, b0_ff.z};
   assign pb1 = '{b1_ff.x, b1_ff.y, b1_ff.z};
   assign tf  = a0_ff.ticks;
   assign tt  = b0_ff.ticks;

   always_comb begin
      fwd   = to0_ff > from0_ff;
      same  = to0_ff == from0_ff;
      pdiff = {1'b0, pe0_ff} - {1'b0, ps0_ff};
      nt    = pdiff[16] ? 16'(-pdiff) : pdiff[15:0];
      if (!same) nt = pe0_ff;
      ml    = (ps0_ff < tf) ? ps0_ff : tf;
      mt    = (nt < tt) ? nt : tt;

      c1_in.fwd  = fwd;
      c1_in.tneg = same && pdiff[16];
      if (!qry0_ff) begin
         c1_in.fl = '{zero: 1'b1,
                      status: wbad0_ff ? kti_pkg::ST_RANGE : kti_pkg::ST_OK};
      end else if (rbad0_ff) begin
         c1_in.fl = '{zero: 1'b1, status: kti_pkg::ST_RANGE};
      end else if (tt == '0 || (fwd && tf == '0)) begin
         c1_in.fl = '{zero: 1'b1, status: kti_pkg::ST_ZERO_DUR};
      end else begin
         c1_in.fl = '{zero: 1'b0, status: kti_pkg::ST_OK};
      end
      for (int a = 0; a < 3; a++) begin
         c1_in.dfrom[a] = 33'(pa1[a]) - 33'(pa0[a]);
         c1_in.dto[a]   = 33'(pb1[a]) - 33'(pb0[a]);
         c1_in.mid[a]   = 33'(pb0[a]) - 33'(pa1[a]);
      end
      // a full ratio is settled up front; the remaining bits are then zero
      dl1_in = '{top: ml == tf, q: '0, r: (ml == tf) ? '0 : ml, d: tf};
      dt1_in = '{top: mt == tt, q: '0, r: (mt == tt) ? '0 : mt, d: tt};
   end

   // ---------------- stages 1..6: context and ratio dividers ----------------
   always_ff @(posedge clock) begin
      if (en[1]) begin
         c_ff[1]  <= c1_in;
         dl_ff[1] <= dl1_in;
         dt_ff[1] <= dt1_in;
      end
      for (int k = 2; k <= 5; k++) begin
         if (en[k]) begin
            c_ff[k]  <= c_ff[k-1];
            dl_ff[k] <= kti_pkg::div_step(dl_ff[k-1]);
            dt_ff[k] <= kti_pkg::div_step(dt_ff[k-1]);
         end
      end
      if (en[6]) begin
         c_ff[6] <= c_ff[5];
      end
   end

   // ---------------- stage 6: delta times ratio ----------------
   logic [16:0]        lead;
   logic signed [17:0] trail;
   logic signed [50:0] pl_ff [3], pt_ff [3];

   always_comb begin
      lead  = 17'd65536 - {dl_ff[5].top, dl_ff[5].q};
      trail = 18'({dt_ff[5].top, dt_ff[5].q});
      if (c_ff[5].tneg) trail = -trail;
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         for (int a = 0; a < 3; a++) begin
            pl_ff[a] <= 51'($signed(c_ff[5].dfrom[a]) * $signed({1'b0, lead}));
            pt_ff[a] <= 51'($signed(c_ff[5].dto[a]) * trail);
         end
      end
   end

   // ---------------- stage 7: accumulate ----------------
   logic signed [35:0] acc_ff [3];
   logic signed [35:0] acc_in [3];
   kti_pkg::fl_type    fl_ff [7:9];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         acc_in[a] = 36'(kti_pkg::rnd51(pt_ff[a]));
         if (c_ff[6].fwd) begin
            acc_in[a] = acc_in[a] + 36'(kti_pkg::rnd51(pl_ff[a]))
                        + 36'($signed(c_ff[6].mid[a]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         fl_ff[7] <= c_ff[6].fl;
         acc_ff   <= acc_in;
      end
   end

   // ---------------- stage 8: rotation products ----------------
   logic signed [53:0] rp_ff [3][3];

   always_ff @(posedge clock) begin
      if (en[8]) begin
         fl_ff[8] <= fl_ff[7];
         for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 3; j++) begin
               rp_ff[r][j] <= 54'($signed(row_ff[r][kti_pkg::COEF_W*j +: kti_pkg::COEF_W])
                                  * acc_ff[j]);
            end
         end
      end
   end

   // ---------------- stage 9: row sums ----------------
   logic signed [55:0] sum_ff [3];

   always_ff @(posedge clock) begin
      if (en[9]) begin
         fl_ff[9] <= fl_ff[8];
         for (int r = 0; r < 3; r++) begin
            sum_ff[r] <= 56'(rp_ff[r][0]) + 56'(rp_ff[r][1]) + 56'(rp_ff[r][2]);
         end
      end
   end

   // ---------------- stage 10: round, offset, saturate ----------------
   logic signed [40:0] fin [3];
   logic signed [31:0] sat [3];
   kti_pkg::rsp_type   rsp_ff, rsp_in;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         fin[r] = 41'(kti_pkg::rnd56(sum_ff[r])) + 41'(base_ff[r]);
         if (fin[r] > 41'sd2147483647) begin
            sat[r] = 32'sh7fffffff;
         end else if (fin[r] < -41'sd2147483648) begin
            sat[r] = 32'sh80000000;
         end else begin
            sat[r] = fin[r][31:0];
         end
         if (fl_ff[9].zero) sat[r] = '0;
      end
      rsp_in = '{out_x: sat[0], out_y: sat[1], out_z: sat[2], status: fl_ff[9].status};
   end

   always_ff @(posedge clock) begin
      if (en[10]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = v_ff[N-1];
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/core/kti_chk.sv */
// ----------------------------------------------------------------------------
// kti_chk: port checker for keyframe_translation_interp
// Watches the top level ports and flags handshake and result slips.
// ----------------------------------------------------------------------------
module kti_chk (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input kti_pkg::rsp_type          rsp_data
);

   // a stalled rsp word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed while stalled");

   // an empty output stage means the whole pipe can move
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with empty output stage");

   // error words carry zero coordinates
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != kti_pkg::ST_OK |->
         rsp_data.out_x == '0 && rsp_data.out_y == '0 && rsp_data.out_z == '0)
      else $error("error word with nonzero coordinates");

   // nothing leaves right after reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid right after reset");

endmodule

bind keyframe_translation_interp kti_chk u_kti_chk (.*);
